// File: sv/nbnd_pkg.sv
package nbnd_pkg;

  // Default sizes
  localparam int PACKET_BYTES_DEF = 1024;
  localparam int SCOPE_BYTES_DEF  = 32;
  localparam int NAME_MAX_BYTES   = 32;

  // Offset arithmetic width: covers a 14-bit pointer target plus a label length
  localparam int OFF_W = 16;

  // Encoding constants
  localparam logic [1:0] PTR_TAG      = 2'b11;
  localparam logic [3:0] MAX_PTR_HOPS = 4'd10;
  localparam logic [7:0] CHAR_A       = 8'h41;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [4:0] TYPED_NAME_LEN = 5'd16;
  localparam logic [3:0] LAST_PAD_POS   = 4'd14;
  localparam logic [4:0] TYPE_POS       = 5'd15;

  // Result kinds
  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_SCOPE = 2'd1;
  localparam logic [1:0] KIND_FINAL = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_PTR_RD,
    ST_PTR_CHK,
    ST_PTR_LO,
    ST_NAME_RD_A,
    ST_NAME_RD_B,
    ST_NAME_WR,
    ST_NAME_END,
    ST_SCOPE_RD,
    ST_SCOPE_WR,
    ST_EM_START,
    ST_EM_RD,
    ST_EM_LD,
    ST_FINAL
  } nbnd_state_t;

  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] char_value;
    logic       status;
    logic [9:0] consumed;
    logic [7:0] type_byte;
    logic       has_type;
    logic       last_result;
  } nbnd_item_t;

endpackage

// File: sv/nbnd_out_stage.sv
module nbnd_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               ld,
  input  nbnd_pkg::nbnd_item_t ld_item,
  input  logic               out_stall,
  output logic               slot_free,
  output logic               out_valid,
  output nbnd_pkg::nbnd_item_t out_item
);
  import nbnd_pkg::*;

  logic       valid_r;
  nbnd_item_t item_r;

  // Slot is free when empty or being taken this cycle
  assign slot_free = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ld) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      item_r <= ld_item;
    end
  end

endmodule

// File: sv/netbios_name_decoder_unit.sv
// Channel   Ports                                                   Handshake
// input     in_data_byte, in_last_byte, in_start_offset             in_valid / in_stall
// result    out_item_kind, out_char_value, out_status, out_consumed,
//           out_type_byte, out_has_type, out_last_result            out_valid / out_stall
//
// Packet bytes are taken one per cycle into the packet memory. After the last
// byte the sequencer walks the memory through its single read port, with a
// registered read for each pointer byte, label length, name byte and scope
// byte; results then leave one at a time from the character memory. Input
// stalls from the last byte until the final status request is loaded. Reset is
// synchronous, active low; memories are not cleared. A stalled result holds in
// the output register.
module netbios_name_decoder_unit #(
  parameter int PACKET_BYTES = nbnd_pkg::PACKET_BYTES_DEF,
  parameter int SCOPE_BYTES  = nbnd_pkg::SCOPE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic [9:0] in_start_offset,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_item_kind,
  output logic [7:0] out_char_value,
  output logic       out_status,
  output logic [9:0] out_consumed,
  output logic [7:0] out_type_byte,
  output logic       out_has_type,
  output logic       out_last_result
);
  import nbnd_pkg::*;

  localparam int AW         = $clog2(PACKET_BYTES);
  localparam int CW         = $clog2(PACKET_BYTES + 1);
  localparam int CHAR_DEPTH = NAME_MAX_BYTES + SCOPE_BYTES;
  localparam int CAW        = $clog2(CHAR_DEPTH);
  localparam int SNW        = $clog2(SCOPE_BYTES + 1);

  nbnd_state_t state_r, state_nxt;

  logic [CW-1:0]    count_r, count_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [OFF_W-1:0] len_r, len_nxt;
  logic [9:0]       used_r, used_nxt;
  logic             got_ptr_r, got_ptr_nxt;
  logic [3:0]       hops_r, hops_nxt;
  logic             scope_ph_r, scope_ph_nxt;
  logic [5:0]       ptr_hi_r, ptr_hi_nxt;
  logic [7:0]       m_r, m_nxt;
  logic [4:0]       n_r, n_nxt;
  logic [3:0]       lns_r, lns_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [4:0]       name_len_r, name_len_nxt;
  logic             has_type_r, has_type_nxt;
  logic [SNW-1:0]   sn_r, sn_nxt;
  logic [7:0]       c1_r, c1_nxt;
  logic             fail_r, fail_nxt;
  logic [CAW-1:0]   em_idx_r, em_idx_nxt;
  logic [CAW-1:0]   total_r, total_nxt;

  // Packet memory ports
  logic             pw_en;
  logic             pr_en;
  logic [OFF_W-1:0] pr_addr;
  logic [7:0]       pr_q_r;
  logic             pr_oob_r;
  logic [7:0]       pdata;
  logic [7:0]       pkt_mem [PACKET_BYTES];

  // Character memory ports
  logic             cw_en;
  logic [CAW-1:0]   cw_addr;
  logic [7:0]       cw_data;
  logic             cr_en;
  logic [7:0]       cr_q_r;
  logic [7:0]       char_mem [CHAR_DEPTH];

  // Output stage
  logic       ld;
  nbnd_item_t ld_item;
  nbnd_item_t out_item;
  logic       slot_free;

  logic             in_acc;
  logic             room;
  logic [CW-1:0]    count_inc;
  logic [OFF_W-1:0] ptr_tgt;
  logic [7:0]       c1d, c2d, nbyte;
  logic [SNW-1:0]   sn_dot;
  logic [8:0]       scope_need;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign room      = (count_r < CW'(PACKET_BYTES));
  assign count_inc = count_r + CW'(room);
  assign pw_en     = in_acc && room;
  assign pdata     = pr_oob_r ? 8'h00 : pr_q_r;

  assign ptr_tgt    = {{(OFF_W-14){1'b0}}, ptr_hi_r, pdata};
  assign c1d        = c1_r - CHAR_A;
  assign c2d        = pdata - CHAR_A;
  assign nbyte      = {c1d[3:0], c2d[3:0]};
  assign sn_dot     = sn_r + SNW'(sn_r != '0);
  assign scope_need = 9'(sn_dot) + 9'(pdata) + 9'd1;

  // Packet memory: write while loading, registered read
  always_ff @(posedge clk) begin
    if (pw_en) begin
      pkt_mem[count_r[AW-1:0]] <= in_data_byte;
    end
    if (pr_en) begin
      pr_q_r   <= pkt_mem[pr_addr[AW-1:0]];
      pr_oob_r <= (pr_addr >= OFF_W'(PACKET_BYTES));
    end
  end

  // Character memory: decoded name then scope bytes
  always_ff @(posedge clk) begin
    if (cw_en) begin
      char_mem[cw_addr] <= cw_data;
    end
    if (cr_en) begin
      cr_q_r <= char_mem[em_idx_r];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers of the decode
  always_ff @(posedge clk) begin
    off_r      <= off_nxt;
    len_r      <= len_nxt;
    used_r     <= used_nxt;
    got_ptr_r  <= got_ptr_nxt;
    hops_r     <= hops_nxt;
    scope_ph_r <= scope_ph_nxt;
    ptr_hi_r   <= ptr_hi_nxt;
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    lns_r      <= lns_nxt;
    type_r     <= type_nxt;
    name_len_r <= name_len_nxt;
    has_type_r <= has_type_nxt;
    sn_r       <= sn_nxt;
    c1_r       <= c1_nxt;
    fail_r     <= fail_nxt;
    em_idx_r   <= em_idx_nxt;
    total_r    <= total_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    off_nxt      = off_r;
    len_nxt      = len_r;
    used_nxt     = used_r;
    got_ptr_nxt  = got_ptr_r;
    hops_nxt     = hops_r;
    scope_ph_nxt = scope_ph_r;
    ptr_hi_nxt   = ptr_hi_r;
    m_nxt        = m_r;
    n_nxt        = n_r;
    lns_nxt      = lns_r;
    type_nxt     = type_r;
    name_len_nxt = name_len_r;
    has_type_nxt = has_type_r;
    sn_nxt       = sn_r;
    c1_nxt       = c1_r;
    fail_nxt     = fail_r;
    em_idx_nxt   = em_idx_r;
    total_nxt    = total_r;
    pr_en        = 1'b0;
    pr_addr      = off_r;
    cw_en        = 1'b0;
    cw_addr      = CAW'(n_r);
    cw_data      = nbyte;
    cr_en        = 1'b0;
    ld           = 1'b0;
    ld_item      = '0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          count_nxt = count_inc;
          if (in_last_byte) begin
            len_nxt   = OFF_W'(count_inc);
            off_nxt   = OFF_W'(in_start_offset);
            count_nxt = '0;
            state_nxt = ST_START;
          end
        end
      end

      ST_START: begin
        used_nxt     = '0;
        got_ptr_nxt  = 1'b0;
        hops_nxt     = '0;
        scope_ph_nxt = 1'b0;
        n_nxt        = '0;
        lns_nxt      = '0;
        type_nxt     = '0;
        has_type_nxt = 1'b0;
        sn_nxt       = '0;
        fail_nxt     = 1'b0;
        if (len_r < off_r + OFF_W'(2)) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_FINAL;
        end else begin
          state_nxt = ST_PTR_RD;
        end
      end

      ST_PTR_RD: begin
        pr_en     = 1'b1;
        state_nxt = ST_PTR_CHK;
      end

      ST_PTR_CHK: begin
        if (pdata[7:6] == PTR_TAG) begin
          // pointer: fetch its low byte
          ptr_hi_nxt = pdata[5:0];
          pr_en      = 1'b1;
          pr_addr    = off_r + OFF_W'(1);
          state_nxt  = ST_PTR_LO;
        end else if (scope_ph_r) begin
          hops_nxt = '0;
          if (pdata == 8'h00) begin
            state_nxt = ST_EM_START;
          end else begin
            if (!got_ptr_r) begin
              used_nxt = used_r + 10'(pdata) + 10'd1;
            end
            // separator between scope labels
            if (sn_r != '0) begin
              cw_en   = 1'b1;
              cw_addr = CAW'(name_len_r) + CAW'(sn_r);
              cw_data = CHAR_DOT;
            end
            sn_nxt = sn_dot;
            m_nxt  = pdata;
            off_nxt = off_r + OFF_W'(1);
            if ((off_r + OFF_W'(pdata) + OFF_W'(2) > len_r) ||
                (scope_need > 9'(SCOPE_BYTES))) begin
              fail_nxt  = 1'b1;
              state_nxt = ST_FINAL;
            end else begin
              state_nxt = ST_SCOPE_RD;
            end
          end
        end else begin
          // name label length
          hops_nxt = '0;
          m_nxt    = {3'b000, pdata[5:1]};
          off_nxt  = off_r + OFF_W'(1);
          if (!got_ptr_r) begin
            used_nxt = used_r + 10'(pdata) + 10'd2;
          end
          if ((pdata == 8'h00) || (pdata[7:6] != 2'b00) || pdata[0] ||
              (off_r + OFF_W'(pdata) + OFF_W'(2) > len_r)) begin
            fail_nxt  = 1'b1;
            state_nxt = ST_FINAL;
          end else begin
            state_nxt = ST_NAME_RD_A;
          end
        end
      end

      ST_PTR_LO: begin
        if (!got_ptr_r) begin
          used_nxt = used_r + 10'd2;
        end
        got_ptr_nxt = 1'b1;
        off_nxt     = ptr_tgt;
        hops_nxt    = hops_r + 4'd1;
        if ((hops_r == MAX_PTR_HOPS) || (ptr_tgt + OFF_W'(2) > len_r)) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_FINAL;
        end else begin
          state_nxt = ST_PTR_RD;
        end
      end

      ST_NAME_RD_A: begin
        pr_en     = 1'b1;
        state_nxt = ST_NAME_RD_B;
      end

      ST_NAME_RD_B: begin
        c1_nxt    = pdata;
        pr_en     = 1'b1;
        pr_addr   = off_r + OFF_W'(1);
        state_nxt = ST_NAME_WR;
      end

      ST_NAME_WR: begin
        if ((c1d[7:4] != 4'h0) || (c2d[7:4] != 4'h0)) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_FINAL;
        end else begin
          cw_en   = 1'b1;
          cw_addr = CAW'(n_r);
          cw_data = nbyte;
          // track last non-space among the padded positions, and the type byte
          if ((n_r != 5'd0) && (n_r <= 5'(LAST_PAD_POS)) && (nbyte != CHAR_SPACE)) begin
            lns_nxt = n_r[3:0];
          end
          if (n_r == TYPE_POS) begin
            type_nxt = nbyte;
          end
          n_nxt   = n_r + 5'd1;
          off_nxt = off_r + OFF_W'(2);
          m_nxt   = m_r - 8'd1;
          state_nxt = (m_r == 8'd1) ? ST_NAME_END : ST_NAME_RD_A;
        end
      end

      ST_NAME_END: begin
        if (n_r == TYPED_NAME_LEN) begin
          has_type_nxt = 1'b1;
          name_len_nxt = 5'(lns_r) + 5'd1;
        end else begin
          name_len_nxt = n_r;
        end
        scope_ph_nxt = 1'b1;
        hops_nxt     = '0;
        state_nxt    = ST_PTR_RD;
      end

      ST_SCOPE_RD: begin
        pr_en     = 1'b1;
        state_nxt = ST_SCOPE_WR;
      end

      ST_SCOPE_WR: begin
        cw_en   = 1'b1;
        cw_addr = CAW'(name_len_r) + CAW'(sn_r);
        cw_data = pdata;
        sn_nxt  = sn_r + SNW'(1);
        off_nxt = off_r + OFF_W'(1);
        m_nxt   = m_r - 8'd1;
        state_nxt = (m_r == 8'd1) ? ST_PTR_RD : ST_SCOPE_RD;
      end

      ST_EM_START: begin
        total_nxt  = CAW'(name_len_r) + CAW'(sn_r);
        em_idx_nxt = '0;
        state_nxt  = ((CAW'(name_len_r) + CAW'(sn_r)) == '0) ? ST_FINAL : ST_EM_RD;
      end

      ST_EM_RD: begin
        cr_en     = 1'b1;
        state_nxt = ST_EM_LD;
      end

      ST_EM_LD: begin
        if (slot_free) begin
          ld                 = 1'b1;
          ld_item.item_kind  = (em_idx_r < CAW'(name_len_r)) ? KIND_NAME : KIND_SCOPE;
          ld_item.char_value = cr_q_r;
          em_idx_nxt         = em_idx_r + CAW'(1);
          state_nxt = ((em_idx_r + CAW'(1)) == total_r) ? ST_FINAL : ST_EM_RD;
        end
      end

      ST_FINAL: begin
        if (slot_free) begin
          ld                  = 1'b1;
          ld_item.item_kind   = KIND_FINAL;
          ld_item.status      = fail_r;
          ld_item.consumed    = fail_r ? 10'd0 : used_r;
          ld_item.has_type    = !fail_r && has_type_r;
          ld_item.type_byte   = (!fail_r && has_type_r) ? type_r : 8'h00;
          ld_item.last_result = 1'b1;
          state_nxt           = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  nbnd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (ld),
    .ld_item   (ld_item),
    .out_stall (out_stall),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_item_kind   = out_item.item_kind;
  assign out_char_value  = out_item.char_value;
  assign out_status      = out_item.status;
  assign out_consumed    = out_item.consumed;
  assign out_type_byte   = out_item.type_byte;
  assign out_has_type    = out_item.has_type;
  assign out_last_result = out_item.last_result;

endmodule
